// File: design/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants and types of the ray / triangle intersection unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int BARY_BITS     = 16;
  localparam int QUOT_LOG      = 40;
  localparam int REG_WIDTH     = 63;
  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_VERTEX_C = 3'd2,
    REG_NORMAL_A = 3'd3,
    REG_NORMAL_B = 3'd4,
    REG_NORMAL_C = 3'd5
  } cfg_reg_t;

  typedef logic [BARY_BITS:0] bary_t;

  localparam bary_t BARY_ONE = bary_t'(1) << BARY_BITS;

endpackage

// File: design/rti_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_intf
// Ray request channel and intersection result channel.
// ----------------------------------------------------------------------------
interface rti_ray_if #(parameter int COORD_WIDTH = 21) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] t_min;
  logic signed [COORD_WIDTH-1:0] t_max;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_min, t_max, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                t_min, t_max, output ready);
endinterface

interface rti_hit_if #(parameter int COORD_WIDTH = 21) ();
  import rti_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_t;
  bary_t                         bary_u;
  bary_t                         bary_v;
  logic signed [COORD_WIDTH-1:0] shade_normal_x;
  logic signed [COORD_WIDTH-1:0] shade_normal_y;
  logic signed [COORD_WIDTH-1:0] shade_normal_z;

  modport source (output valid, hit, hit_t, bary_u, bary_v, shade_normal_x,
                  shade_normal_y, shade_normal_z, input ready);
  modport sink (input valid, hit, hit_t, bary_u, bary_v, shade_normal_x,
                shade_normal_y, shade_normal_z, output ready);
endinterface

// File: design/ray_triangle_intersect_unit.sv
`timescale 1ns / 1ps
// Throughput: one ray per cycle while the skid entry is free; the 41-stage
// restoring divider (one quotient bit per stage) sets the depth. A one-entry
// skid behind the output register keeps the pipe running while a result waits
// to be taken, until the skid entry itself is full.
// Reset: synchronous; clears all valid bits and the triangle registers.
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit
// Pipelined Moller-Trumbore ray / triangle test in signed fixed point.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [rti_pkg::CFG_IDX_WIDTH-1:0] wr_index,
  input  logic [rti_pkg::REG_WIDTH-1:0]     wr_data,
  rti_ray_if.sink                           ray,
  rti_hit_if.source                         res
);
  import rti_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;
  localparam int PMW = W + EW;
  localparam int QMW = 2 * EW;
  localparam int CW  = 2 * EW + 1;
  localparam int MW  = CW + EW;
  localparam int DW  = MW + 2;
  localparam int NX  = DW + 1;
  localparam int NW  = NX + FRAC_BITS + 1;
  localparam int UW  = NX + BARY_BITS;
  localparam int QB  = QUOT_LOG + 1;
  localparam int TW  = QB + 1;
  localparam int PNW = W + BARY_BITS + 2;
  localparam int AW  = PNW + 2;
  localparam int SPL = EW;
  localparam int HW  = CW - SPL;
  localparam int PPW = HW + EW;

  localparam int NST = QB + 10;

  localparam logic signed [W-1:0] TINF = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] TNEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [QB-1:0]       QCAP = QB'(1) << QUOT_LOG;
  localparam logic signed [AW-1:0] ROUND = AW'(1) << (BARY_BITS - 1);

  // triangle registers
  logic [REG_WIDTH-1:0] vtx_a, vtx_b, vtx_c, nrm_a, nrm_b, nrm_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_a <= '0;
      vtx_b <= '0;
      vtx_c <= '0;
      nrm_a <= '0;
      nrm_b <= '0;
      nrm_c <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_VERTEX_A: vtx_a <= wr_data;
        REG_VERTEX_B: vtx_b <= wr_data;
        REG_VERTEX_C: vtx_c <= wr_data;
        REG_NORMAL_A: nrm_a <= wr_data;
        REG_NORMAL_B: nrm_b <= wr_data;
        REG_NORMAL_C: nrm_c <= wr_data;
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] va [3], vb [3], vc [3], na [3], nb [3], nc [3];
  logic signed [W-1:0] o_in [3], d_in [3];

  for (genvar k = 0; k < 3; k++) begin : g_coord
    assign va[k] = vtx_a[k*W +: W];
    assign vb[k] = vtx_b[k*W +: W];
    assign vc[k] = vtx_c[k*W +: W];
    assign na[k] = nrm_a[k*W +: W];
    assign nb[k] = nrm_b[k*W +: W];
    assign nc[k] = nrm_c[k*W +: W];
  end

  assign o_in[0] = ray.origin_x;
  assign o_in[1] = ray.origin_y;
  assign o_in[2] = ray.origin_z;
  assign d_in[0] = ray.dir_x;
  assign d_in[1] = ray.dir_y;
  assign d_in[2] = ray.dir_z;

  // pipeline control: whole pipe advances while the skid entry is free
  logic           en;
  logic [NST-1:0] v;
  logic           out_v, skid_v;

  assign en        = !skid_v;
  assign ray.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], ray.valid};
    end
  end

  // stage: edges and origin offset
  logic signed [W-1:0]  s0_d [3];
  logic signed [EW-1:0] s0_e1 [3], s0_e2 [3], s0_s [3];
  logic signed [W-1:0]  s0_tmin, s0_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s0_d[k]  <= d_in[k];
        s0_e1[k] <= EW'(vb[k]) - EW'(va[k]);
        s0_e2[k] <= EW'(vc[k]) - EW'(va[k]);
        s0_s[k]  <= EW'(o_in[k]) - EW'(va[k]);
      end
      s0_tmin <= ray.t_min;
      s0_tmax <= ray.t_max;
    end
  end

  // stage: cross product terms P = d x e2, Q = s x e1
  logic signed [PMW-1:0] s1_pm [6];
  logic signed [QMW-1:0] s1_qm [6];
  logic signed [W-1:0]   s1_d [3];
  logic signed [EW-1:0]  s1_e1 [3], s1_e2 [3], s1_s [3];
  logic signed [W-1:0]   s1_tmin, s1_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_pm[2*k]   <= PMW'(s0_d[(k+1)%3]) * PMW'(s0_e2[(k+2)%3]);
        s1_pm[2*k+1] <= PMW'(s0_d[(k+2)%3]) * PMW'(s0_e2[(k+1)%3]);
        s1_qm[2*k]   <= QMW'(s0_s[(k+1)%3]) * QMW'(s0_e1[(k+2)%3]);
        s1_qm[2*k+1] <= QMW'(s0_s[(k+2)%3]) * QMW'(s0_e1[(k+1)%3]);
        s1_d[k]  <= s0_d[k];
        s1_e1[k] <= s0_e1[k];
        s1_e2[k] <= s0_e2[k];
        s1_s[k]  <= s0_s[k];
      end
      s1_tmin <= s0_tmin;
      s1_tmax <= s0_tmax;
    end
  end

  // stage: cross product differences
  logic signed [CW-1:0] s2_p [3], s2_q [3];
  logic signed [W-1:0]  s2_d [3];
  logic signed [EW-1:0] s2_e1 [3], s2_e2 [3], s2_s [3];
  logic signed [W-1:0]  s2_tmin, s2_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_p[k]  <= CW'(s1_pm[2*k]) - CW'(s1_pm[2*k+1]);
        s2_q[k]  <= CW'(s1_qm[2*k]) - CW'(s1_qm[2*k+1]);
        s2_d[k]  <= s1_d[k];
        s2_e1[k] <= s1_e1[k];
        s2_e2[k] <= s1_e2[k];
        s2_s[k]  <= s1_s[k];
      end
      s2_tmin <= s1_tmin;
      s2_tmax <= s1_tmax;
    end
  end

  // stage: dot product partial terms; split each cross product into a
  // signed high half and an unsigned low half of SPL bits
  logic signed [HW-1:0] p_hi [3], q_hi [3];
  logic signed [SPL:0]  p_lo [3], q_lo [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_hi[k] = s2_p[k][CW-1:SPL];
      q_hi[k] = s2_q[k][CW-1:SPL];
      p_lo[k] = {1'b0, s2_p[k][SPL-1:0]};
      q_lo[k] = {1'b0, s2_q[k][SPL-1:0]};
    end
  end

  logic signed [PPW-1:0] pp_det_h [3], pp_det_l [3], pp_nu_h [3], pp_nu_l [3];
  logic signed [PPW-1:0] pp_nv_h [3], pp_nv_l [3], pp_nt_h [3], pp_nt_l [3];
  logic signed [W-1:0]   pp_tmin, pp_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pp_det_h[k] <= PPW'(p_hi[k]) * PPW'(s2_e1[k]);
        pp_det_l[k] <= PPW'(p_lo[k]) * PPW'(s2_e1[k]);
        pp_nu_h[k]  <= PPW'(p_hi[k]) * PPW'(s2_s[k]);
        pp_nu_l[k]  <= PPW'(p_lo[k]) * PPW'(s2_s[k]);
        pp_nv_h[k]  <= PPW'(q_hi[k]) * PPW'(s2_d[k]);
        pp_nv_l[k]  <= PPW'(q_lo[k]) * PPW'(s2_d[k]);
        pp_nt_h[k]  <= PPW'(q_hi[k]) * PPW'(s2_e2[k]);
        pp_nt_l[k]  <= PPW'(q_lo[k]) * PPW'(s2_e2[k]);
      end
      pp_tmin <= s2_tmin;
      pp_tmax <= s2_tmax;
    end
  end

  // stage: dot product terms
  logic signed [MW-1:0] s3_det [3], s3_nu [3], s3_nv [3], s3_nt [3];
  logic signed [W-1:0]  s3_tmin, s3_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_det[k] <= (MW'(pp_det_h[k]) <<< SPL) + MW'(pp_det_l[k]);
        s3_nu[k]  <= (MW'(pp_nu_h[k]) <<< SPL) + MW'(pp_nu_l[k]);
        s3_nv[k]  <= (MW'(pp_nv_h[k]) <<< SPL) + MW'(pp_nv_l[k]);
        s3_nt[k]  <= (MW'(pp_nt_h[k]) <<< SPL) + MW'(pp_nt_l[k]);
      end
      s3_tmin <= pp_tmin;
      s3_tmax <= pp_tmax;
    end
  end

  // stage: dot product sums
  logic signed [DW-1:0] s4_det, s4_nu, s4_nv, s4_nt;
  logic signed [W-1:0]  s4_tmin, s4_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_det  <= DW'(s3_det[0]) + DW'(s3_det[1]) + DW'(s3_det[2]);
      s4_nu   <= DW'(s3_nu[0]) + DW'(s3_nu[1]) + DW'(s3_nu[2]);
      s4_nv   <= DW'(s3_nv[0]) + DW'(s3_nv[1]) + DW'(s3_nv[2]);
      s4_nt   <= DW'(s3_nt[0]) + DW'(s3_nt[1]) + DW'(s3_nt[2]);
      s4_tmin <= s3_tmin;
      s4_tmax <= s3_tmax;
    end
  end

  // stage: make the determinant positive
  logic signed [NX-1:0] s5_det, s5_nu, s5_nv, s5_nt;
  logic                 s5_zero;
  logic signed [W-1:0]  s5_tmin, s5_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s4_det < 0) begin
        s5_det <= -NX'(s4_det);
        s5_nu  <= -NX'(s4_nu);
        s5_nv  <= -NX'(s4_nv);
        s5_nt  <= -NX'(s4_nt);
      end else begin
        s5_det <= NX'(s4_det);
        s5_nu  <= NX'(s4_nu);
        s5_nv  <= NX'(s4_nv);
        s5_nt  <= NX'(s4_nt);
      end
      s5_zero <= (s4_det == '0);
      s5_tmin <= s4_tmin;
      s5_tmax <= s4_tmax;
    end
  end

  // divider stages; entry 0 is the set-up stage
  logic [NX-1:0]       dv_det [QB+1];
  logic [NW-1:0]       dv_rt [QB+1];
  logic [QB-1:0]       dv_qt [QB+1];
  logic [UW-1:0]       dv_ru [QB+1], dv_rv [QB+1];
  bary_t               dv_qu [QB+1], dv_qv [QB+1];
  logic                dv_miss [QB+1], dv_neg [QB+1], dv_ovf [QB+1];
  logic signed [W-1:0] dv_tmin [QB+1], dv_tmax [QB+1];

  logic [NX:0]   pr_sum;
  logic          pr_neg;
  logic [NX-1:0] pr_mag;
  logic [NW-1:0] pr_num;

  always_comb begin
    pr_sum = (NX+1)'(unsigned'(s5_nu)) + (NX+1)'(unsigned'(s5_nv));
    pr_neg = s5_nt[NX-1];
    pr_mag = pr_neg ? NX'(-s5_nt) : NX'(s5_nt);
    // ceiling for a negative t: add det - 1 before the floor division
    pr_num = (NW'(pr_mag) << FRAC_BITS)
           + (pr_neg ? NW'(unsigned'(s5_det)) - NW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_det[0]  <= unsigned'(s5_det);
      dv_rt[0]   <= pr_num;
      dv_qt[0]   <= '0;
      dv_ru[0]   <= UW'(unsigned'(s5_nu)) << BARY_BITS;
      dv_rv[0]   <= UW'(unsigned'(s5_nv)) << BARY_BITS;
      dv_qu[0]   <= '0;
      dv_qv[0]   <= '0;
      dv_miss[0] <= s5_zero || s5_nu[NX-1] || s5_nv[NX-1]
                 || ((NX+1)'(unsigned'(s5_det)) < pr_sum);
      dv_neg[0]  <= pr_neg;
      dv_ovf[0]  <= (pr_num >> QB) >= NW'(unsigned'(s5_det));
      dv_tmin[0] <= s5_tmin;
      dv_tmax[0] <= s5_tmax;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic tk_t;

    assign tk_t = (dv_rt[j] >> B) >= NW'(dv_det[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rt[j+1]   <= tk_t ? dv_rt[j] - (NW'(dv_det[j]) << B) : dv_rt[j];
        dv_qt[j+1]   <= dv_qt[j] | (QB'(tk_t) << B);
        dv_det[j+1]  <= dv_det[j];
        dv_miss[j+1] <= dv_miss[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_ovf[j+1]  <= dv_ovf[j];
        dv_tmin[j+1] <= dv_tmin[j];
        dv_tmax[j+1] <= dv_tmax[j];
      end
    end

    if (B <= BARY_BITS) begin : g_bary
      logic tk_u, tk_v;

      assign tk_u = (dv_ru[j] >> B) >= UW'(dv_det[j]);
      assign tk_v = (dv_rv[j] >> B) >= UW'(dv_det[j]);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_ru[j+1] <= tk_u ? dv_ru[j] - (UW'(dv_det[j]) << B) : dv_ru[j];
          dv_rv[j+1] <= tk_v ? dv_rv[j] - (UW'(dv_det[j]) << B) : dv_rv[j];
          dv_qu[j+1] <= dv_qu[j] | (bary_t'(tk_u) << B);
          dv_qv[j+1] <= dv_qv[j] | (bary_t'(tk_v) << B);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          dv_ru[j+1] <= dv_ru[j];
          dv_rv[j+1] <= dv_rv[j];
          dv_qu[j+1] <= dv_qu[j];
          dv_qv[j+1] <= dv_qv[j];
        end
      end
    end
  end

  // stage: quotient clamp and window test
  logic [QB-1:0]        qs;
  logic signed [TW-1:0] tq;
  logic                 in_win;
  logic signed [W-1:0]  t_sat;

  always_comb begin
    qs = (dv_ovf[QB] || (dv_qt[QB][QB-1] && |dv_qt[QB][QB-2:0])) ? QCAP : dv_qt[QB];
    tq = dv_neg[QB] ? -signed'({1'b0, qs}) : signed'({1'b0, qs});
    in_win = (tq >= TW'(dv_tmin[QB]))
          && ((dv_tmax[QB] == TINF) || (tq <= TW'(dv_tmax[QB])));
    priority if (tq > TW'(TINF)) begin
      t_sat = TINF;
    end else if (tq < TW'(TNEG)) begin
      t_sat = TNEG;
    end else begin
      t_sat = W'(tq);
    end
  end

  logic                q_hit;
  logic signed [W-1:0] q_t;
  bary_t               q_u, q_v, q_w;

  always_ff @(posedge clk) begin
    if (en) begin
      q_hit <= !dv_miss[QB] && in_win;
      q_t   <= t_sat;
      q_u   <= dv_qu[QB];
      q_v   <= dv_qv[QB];
      q_w   <= BARY_ONE - dv_qu[QB] - dv_qv[QB];
    end
  end

  // stage: normal weighting products
  logic signed [PNW-1:0] m_a [3], m_b [3], m_c [3];
  logic                  m_hit;
  logic signed [W-1:0]   m_t;
  bary_t                 m_u, m_v;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_a[k] <= PNW'(na[k]) * signed'(PNW'(q_w));
        m_b[k] <= PNW'(nb[k]) * signed'(PNW'(q_u));
        m_c[k] <= PNW'(nc[k]) * signed'(PNW'(q_v));
      end
      m_hit <= q_hit;
      m_t   <= q_t;
      m_u   <= q_u;
      m_v   <= q_v;
    end
  end

  // result forming
  logic signed [AW-1:0] acc [3], shr [3];
  logic signed [W-1:0]  nsat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = AW'(m_a[k]) + AW'(m_b[k]) + AW'(m_c[k]) + ROUND;
      shr[k] = acc[k] >>> BARY_BITS;
      priority if (shr[k] > AW'(TINF)) begin
        nsat[k] = TINF;
      end else if (shr[k] < AW'(TNEG)) begin
        nsat[k] = TNEG;
      end else begin
        nsat[k] = W'(shr[k]);
      end
    end
  end

  logic                take;
  logic                r_hit, k_hit;
  logic signed [W-1:0] r_t, k_t;
  bary_t               r_u, r_v, k_u, k_v;
  logic signed [W-1:0] r_n [3], k_n [3];

  assign take = en && v[NST-1];

  // zero every field on a miss
  always_comb begin
    r_hit = m_hit;
    r_t   = m_hit ? m_t : '0;
    r_u   = m_hit ? m_u : '0;
    r_v   = m_hit ? m_v : '0;
    for (int k = 0; k < 3; k++) begin
      r_n[k] = m_hit ? nsat[k] : '0;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || res.ready) begin
      out_v  <= skid_v || take;
      skid_v <= 1'b0;
    end else if (take) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || res.ready) begin
      if (skid_v) begin
        res.hit            <= k_hit;
        res.hit_t          <= k_t;
        res.bary_u         <= k_u;
        res.bary_v         <= k_v;
        res.shade_normal_x <= k_n[0];
        res.shade_normal_y <= k_n[1];
        res.shade_normal_z <= k_n[2];
      end else begin
        res.hit            <= r_hit;
        res.hit_t          <= r_t;
        res.bary_u         <= r_u;
        res.bary_v         <= r_v;
        res.shade_normal_x <= r_n[0];
        res.shade_normal_y <= r_n[1];
        res.shade_normal_z <= r_n[2];
      end
    end else if (take) begin
      k_hit <= r_hit;
      k_t   <= r_t;
      k_u   <= r_u;
      k_v   <= r_v;
      k_n   <= r_n;
    end
  end

  assign res.valid = out_v;

endmodule

// File: design/rti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Port-level assertions for the ray / triangle intersection unit.
// ----------------------------------------------------------------------------
module rti_checker #(
  parameter int COORD_WIDTH = 21
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic signed [COORD_WIDTH-1:0] hit_t,
  input rti_pkg::bary_t                bary_u,
  input rti_pkg::bary_t                bary_v,
  input logic signed [COORD_WIDTH-1:0] shade_normal_x,
  input logic signed [COORD_WIDTH-1:0] shade_normal_y,
  input logic signed [COORD_WIDTH-1:0] shade_normal_z
);
  import rti_pkg::*;

  // a stalled result holds its hit flag, t, weights and normal x component
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_t)
      && $stable(bary_u) && $stable(bary_v) && $stable(shade_normal_x))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_t == '0 && bary_u == '0 && bary_v == '0
      && shade_normal_x == '0 && shade_normal_y == '0 && shade_normal_z == '0)
    else $error("miss carries non-zero fields");

  a_bary_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> ((BARY_BITS + 2)'(bary_u) + (BARY_BITS + 2)'(bary_v))
      <= (BARY_BITS + 2)'(BARY_ONE))
    else $error("barycentric weights exceed one");

  // the input only stalls while a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_triangle_intersect_unit rti_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rti_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (ray.ready),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .hit            (res.hit),
  .hit_t          (res.hit_t),
  .bary_u         (res.bary_u),
  .bary_v         (res.bary_v),
  .shade_normal_x (res.shade_normal_x),
  .shade_normal_y (res.shade_normal_y),
  .shade_normal_z (res.shade_normal_z)
);

// File: tb/ray_triangle_intersect_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit_tb
// Streams rays at the intersection unit under several triangles and flow
// patterns, predicts each hit record in fixed point and checks it in order.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit_tb;
  import rti_pkg::*;

  localparam int          CW        = 21;
  localparam int          FB        = 10;
  localparam longint      C_MAX     = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint      C_MIN     = -(64'sd1 <<< (CW - 1));
  localparam logic [2:0]  IDX_SPARE = 3'd7;
  localparam int          LIMIT     = 1_000_000;
  localparam int          DRAIN     = 80;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t T_TOP = coord_t'(C_MAX);
  localparam coord_t T_BOT = coord_t'(C_MIN);

  typedef struct {
    coord_t ox, oy, oz, dx, dy, dz, tmin, tmax;
  } ray_t;

  typedef struct packed {
    logic   hit;
    coord_t t;
    bary_t  u;
    bary_t  v;
    coord_t nx, ny, nz;
  } hit_rec_t;

  // --------------------------------------------------------------------------
  class hit_scoreboard;
    longint   vtx[3][3];
    longint   nrm[3][3];
    hit_rec_t pending[$];
    int       errors, hits, misses;

    function void set_reg(int idx, logic [REG_WIDTH-1:0] d);
      coord_t c;
      for (int k = 0; k < 3; k++) begin
        c = d[k*CW +: CW];
        if (idx < 3) vtx[idx][k] = c;
        else if (idx < 6) nrm[idx-3][k] = c;
      end
    endfunction

    static function wide_t capped_div(wide_t n, wide_t d);
      wide_t q;
      q = n / d;
      return (q > (wide_t'(1) <<< QUOT_LOG)) ? (wide_t'(1) <<< QUOT_LOG) : q;
    endfunction

    static function longint sat(longint x);
      return x > C_MAX ? C_MAX : (x < C_MIN ? C_MIN : x);
    endfunction

    function void note(ray_t r);
      longint   o[3], d[3], e1[3], e2[3], s[3], p[3], q[3];
      longint   tq, uq, vq, wa, acc;
      wide_t    det, nu, nv, nt, num;
      hit_rec_t e;
      coord_t   nn[3];
      logic     neg;
      e = '0;
      o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
      d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
      for (int k = 0; k < 3; k++) begin
        e1[k] = vtx[1][k] - vtx[0][k];
        e2[k] = vtx[2][k] - vtx[0][k];
        s[k]  = o[k] - vtx[0][k];
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = 0; nu = 0; nv = 0; nt = 0;
      for (int k = 0; k < 3; k++) begin
        det += wide_t'(p[k]) * wide_t'(e1[k]);
        nu  += wide_t'(p[k]) * wide_t'(s[k]);
        nv  += wide_t'(q[k]) * wide_t'(d[k]);
        nt  += wide_t'(q[k]) * wide_t'(e2[k]);
      end
      if (det < 0) begin
        det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      if (det != 0 && nu >= 0 && nv >= 0 && det >= nu + nv) begin
        neg = nt < 0;
        num = (neg ? -nt : nt) <<< FB;
        if (neg) num += det - 1;
        tq = longint'(capped_div(num, det));
        if (neg) tq = -tq;
        if (tq >= longint'(r.tmin) && (longint'(r.tmax) == C_MAX || tq <= longint'(r.tmax)))
        begin
          uq = longint'(capped_div(nu <<< BARY_BITS, det));
          vq = longint'(capped_div(nv <<< BARY_BITS, det));
          wa = (64'sd1 <<< BARY_BITS) - uq - vq;
          for (int k = 0; k < 3; k++) begin
            acc = nrm[0][k]*wa + nrm[1][k]*uq + nrm[2][k]*vq;
            nn[k] = coord_t'(sat((acc + (64'sd1 <<< (BARY_BITS-1))) >>> BARY_BITS));
          end
          e.hit = 1'b1;
          e.t   = coord_t'(sat(tq));
          e.u   = bary_t'(uq);
          e.v   = bary_t'(vq);
          e.nx  = nn[0];
          e.ny  = nn[1];
          e.nz  = nn[2];
        end
      end
      pending.push_back(e);
    endfunction

    function void check(hit_rec_t a);
      hit_rec_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b t=%0d", $time, a.hit, a.t);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit) hits++; else misses++;
      if (a !== e) begin
        errors++;
        $display("%0t: mismatch expected hit=%0b t=%0d u=%0d v=%0d n=(%0d,%0d,%0d)",
                 $time, e.hit, e.t, e.u, e.v, e.nx, e.ny, e.nz);
        $display("%0t:          actual   hit=%0b t=%0d u=%0d v=%0d n=(%0d,%0d,%0d)",
                 $time, a.hit, a.t, a.u, a.v, a.nx, a.ny, a.nz);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [2:0]           wr_index = '0;
  logic [REG_WIDTH-1:0] wr_data = '0;

  rti_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
  rti_hit_if #(.COORD_WIDTH(CW)) hit_ch ();

  ray_triangle_intersect_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .ray(ray_ch), .res(hit_ch)
  );

  hit_scoreboard sb = new();
  int     idle_pct, stall_pct, cycles, rays_sent;
  logic   hold_req = 1'b0;
  longint tri_v[3][3];
  longint tri_n[3][3];

  always #2 clk = ~clk;

  initial begin
    ray_ch.valid  = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    ray_ch.t_min = '0; ray_ch.t_max = '0;
    hit_ch.ready  = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[ray_triangle_intersect_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold when requested
  always @(posedge clk) begin : receiver
    int hold_left;
    bit hold_seen;
    if (hold_req && !hold_seen) begin
      hold_left = 400;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      hit_ch.ready <= 1'b0;
    end else begin
      hit_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (ray_ch.valid && ray_ch.ready)
        sb.note('{ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z, ray_ch.dir_x,
                  ray_ch.dir_y, ray_ch.dir_z, ray_ch.t_min, ray_ch.t_max});
      if (hit_ch.valid && hit_ch.ready)
        sb.check('{hit_ch.hit, hit_ch.hit_t, hit_ch.bary_u, hit_ch.bary_v,
                   hit_ch.shade_normal_x, hit_ch.shade_normal_y, hit_ch.shade_normal_z});
    end
  end

  // --------------------------------------------------------------------------
  function automatic logic [REG_WIDTH-1:0] pack3(longint x, longint y, longint z);
    coord_t cx, cy, cz;
    cx = coord_t'(x); cy = coord_t'(y); cz = coord_t'(z);
    return {cz, cy, cx};
  endfunction

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  // Ray from a random origin through the point of the triangle at weights
  // (wu, wv); the hit sits near t = k.
  function automatic ray_t aim(int wu, int wv, int k, longint tmin, longint tmax);
    ray_t   r;
    longint o[3], d[3], pt;
    for (int i = 0; i < 3; i++) begin
      pt = tri_v[0][i] + (((tri_v[1][i] - tri_v[0][i]) * wu
                        + (tri_v[2][i] - tri_v[0][i]) * wv) >>> BARY_BITS);
      o[i] = rnd(-300000, 300000);
      d[i] = hit_scoreboard::sat((pt - o[i]) / k);
    end
    r.ox = coord_t'(o[0]); r.oy = coord_t'(o[1]); r.oz = coord_t'(o[2]);
    r.dx = coord_t'(d[0]); r.dy = coord_t'(d[1]); r.dz = coord_t'(d[2]);
    r.tmin = coord_t'(tmin); r.tmax = coord_t'(tmax);
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
          coord_t'($urandom), coord_t'($urandom)};
    return r;
  endfunction

  function automatic ray_t random_ray();
    int     wu, wv, k;
    longint tmin, tmax;
    if ($urandom_range(9) < 2) return noise_ray();
    wu = $urandom_range(65536);
    wv = $urandom_range(65536 - wu);
    case ($urandom_range(5))
      0: begin wu = 0; end
      1: begin wv = 65536 - wu; end
      2: begin wu = $urandom_range(70000); wv = $urandom_range(70000); end
      default: ;
    endcase
    k = $urandom_range(3) == 0 ? -1 : (1 << $urandom_range(2));
    case ($urandom_range(3))
      0: begin tmin = 0; tmax = C_MAX; end
      1: begin tmin = C_MIN; tmax = rnd(-2000, 6000); end
      2: begin tmin = rnd(0, 4000); tmax = tmin + rnd(0, 4000); end
      default: begin tmin = rnd(C_MIN, C_MAX); tmax = rnd(C_MIN, C_MAX); end
    endcase
    return aim(wu, wv, k, tmin, tmax);
  endfunction

  task automatic send_ray(input ray_t r);
    if ($urandom_range(99) < idle_pct) begin
      ray_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    ray_ch.valid    <= 1'b1;
    ray_ch.origin_x <= r.ox; ray_ch.origin_y <= r.oy; ray_ch.origin_z <= r.oz;
    ray_ch.dir_x    <= r.dx; ray_ch.dir_y    <= r.dy; ray_ch.dir_z    <= r.dz;
    ray_ch.t_min    <= r.tmin; ray_ch.t_max  <= r.tmax;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    rays_sent++;
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write all six registers back to back, after a write to an unused index
  task automatic program_triangle();
    logic [REG_WIDTH-1:0] d;
    wr_en <= 1'b1; wr_index <= IDX_SPARE; wr_data <= REG_WIDTH'({$urandom, $urandom});
    @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      d = i < 3 ? pack3(tri_v[i][0], tri_v[i][1], tri_v[i][2])
                : pack3(tri_n[i-3][0], tri_n[i-3][1], tri_n[i-3][2]);
      wr_index <= cfg_reg_t'(i);
      wr_data  <= d;
      sb.set_reg(i, d);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic pick_triangle(input int kind);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        case (kind)
          0: begin
            tri_v[i][k] = rnd(-60000, 60000);
            tri_n[i][k] = rnd(-2048, 2048);
          end
          1: begin
            tri_v[i][k] = $urandom_range(1) ? rnd(400000, 500000) : rnd(-500000, -400000);
            tri_n[i][k] = $urandom_range(1) ? C_MAX : C_MIN;
          end
          default: begin
            tri_v[i][k] = rnd(-200000, 200000);
            tri_n[i][k] = rnd(C_MIN, C_MAX);
          end
        endcase
      end
  endtask

  // --------------------------------------------------------------------------
  initial begin
    ray_t r;
    idle_pct = 0; stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: every ray sees a degenerate triangle
    tri_v = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
    send_ray(noise_ray());
    send_ray(aim(20000, 20000, 1, 0, C_MAX));
    drain();

    tri_v = '{'{-50000, -40000, 10000}, '{60000, -30000, 20000}, '{0, 70000, -10000}};
    tri_n = '{'{0, 0, 1024}, '{1024, 0, 0}, '{0, -1024, 512}};
    program_triangle();
    send_ray(aim(0, 0, 1, 0, C_MAX));
    send_ray(aim(65536, 0, 1, 0, C_MAX));
    send_ray(aim(0, 65536, 1, 0, C_MAX));
    send_ray(aim(32768, 32768, 2, 0, C_MAX));
    send_ray(aim(21845, 21845, 4, C_MIN, C_MAX - 1));
    send_ray(aim(20000, 10000, -1, C_MIN, C_MAX));
    send_ray(aim(20000, 10000, -1, 0, C_MAX));
    send_ray(aim(20000, 10000, 1, 2000, C_MAX));
    send_ray(aim(20000, 10000, 1, 0, 500));
    send_ray(aim(40000, 40000, 1, 0, C_MAX));
    r = aim(10000, 10000, 1, 0, C_MAX);
    r.dx = 0; r.dy = 0; r.dz = 0;
    send_ray(r);
    send_ray('{0, 0, -100000, T_TOP, T_TOP, T_TOP, T_BOT, T_TOP});
    send_ray('{0, 0, 100000, T_BOT, T_BOT, T_BOT, T_BOT, T_TOP});
    send_ray('{T_TOP, T_TOP, T_TOP, T_BOT, T_BOT, T_BOT, T_BOT, T_TOP});
    send_ray('{T_BOT, T_BOT, T_BOT, T_TOP, T_TOP, T_TOP, T_BOT, T_TOP});
    send_ray('{0, 0, 0, 0, 0, 0, 0, 0});
    send_ray('{-1, -1, -1, -1, -1, -1, -1, -1});
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      pick_triangle(ph == 1 ? 1 : (ph == 3 ? 0 : 2));
      if (ph == 0) pick_triangle(0);
      program_triangle();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      // hold the result side off while rays keep coming, so the pipe backs up
      if (ph == 0) hold_req <= 1'b1;
      for (int n = 0; n < 305; n++) send_ray(random_ray());
      drain();
    end

    $display("Covered %0d rays over seven triangle settings and four flow patterns,",
             rays_sent);
    $display("with %0d hits and %0d misses checked.", sb.hits, sb.misses);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ray_triangle_intersect_unit] OK");
    else
      $display("[ray_triangle_intersect_unit] ERROR");
    $finish;
  end

endmodule
